FILE: design/sorted_time_priority_queue_top_assert.svh
// Assertion macros for the sorted time priority queue
`ifndef SORTED_TIME_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_TIME_PRIORITY_QUEUE_TOP_ASSERT_SVH

// check outside reset
`define STPQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("stpq assertion failed");

// check at every edge, reset included
`define STPQ_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("stpq assertion failed");

`endif

FILE: design/stpq_pkg.sv
// Shared types and codes for the sorted time priority queue
`default_nettype none
package stpq_pkg;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

	localparam int MINUTES_W = 11;
	localparam logic [MINUTES_W-1:0] MINUTES_MAX = 11'd1439;

	typedef struct packed {
		logic                 kind;
		logic [7:0]           item_id;
		logic [MINUTES_W-1:0] minutes;
	} op_t;

	typedef struct packed {
		logic [7:0]           head_id;
		logic [MINUTES_W-1:0] head_minutes;
		logic [4:0]           entry_count;
		logic [1:0]           status;
	} res_t;

endpackage
`default_nettype wire

FILE: design/stpq_fifo.sv
// Two-entry register queue between pipeline parts
`default_nettype none
module stpq_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	output logic              full,
	input  wire logic         rd_en,
	output logic [W-1:0]      rd_data,
	output logic              empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_wr;
	logic         do_rd;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/stpq_front.sv
// Front end: accept words and convert HHMM to minutes
`default_nettype none
module stpq_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        kind,
	input  wire logic [7:0]  item_id,
	input  wire logic [11:0] arrival_hhmm,
	output logic             op_wr,
	output stpq_pkg::op_t    op_data,
	input  wire logic        op_full
);

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  id_s1;
	logic [11:0] hhmm_s1;
	logic [5:0]  hours_s1;
	logic        accept;
	logic [24:0] recip_prod;
	logic [11:0] rem_min;
	logic [11:0] total_min;

	assign full       = valid_s1 && op_full;
	assign accept     = push && !full;
	// hhmm / 100 by reciprocal, exact for 12-bit inputs
	assign recip_prod = 25'(arrival_hhmm) * 25'd5243;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!op_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			id_s1    <= item_id;
			hhmm_s1  <= arrival_hhmm;
			hours_s1 <= recip_prod[24:19];
		end
	end

	assign rem_min   = hhmm_s1 - 12'(hours_s1) * 12'd100;
	assign total_min = 12'(hours_s1) * 12'd60 + rem_min;

	always_comb begin
		op_wr           = valid_s1;
		op_data.kind    = kind_s1;
		op_data.item_id = id_s1;
		if (total_min > 12'(stpq_pkg::MINUTES_MAX)) begin
			op_data.minutes = stpq_pkg::MINUTES_MAX;
		end else begin
			op_data.minutes = total_min[stpq_pkg::MINUTES_W-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: design/stpq_back.sv
// Back end: sorted shift chain that executes push and pop
`default_nettype none
module stpq_back #(
	parameter int DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        op_valid,
	input  stpq_pkg::op_t    op_data,
	output logic             op_rd,
	input  wire logic        res_full,
	output logic             res_wr,
	output stpq_pkg::res_t   res_data
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [stpq_pkg::MINUTES_W-1:0] key_q [DEPTH];
	logic [7:0]                     id_q  [DEPTH];
	logic [CW-1:0]                  occ_q;
	logic [CW-1:0]                  occ_nxt;
	logic [DEPTH-1:0]               take;
	logic                           fire;
	logic                           push_ok;
	logic                           pop_ok;
	logic                           is_full;
	logic                           is_empty;

	assign fire     = op_valid && !res_full;
	assign op_rd    = fire;
	assign res_wr   = fire;
	assign is_full  = (occ_q == CW'(DEPTH));
	assign is_empty = (occ_q == '0);
	assign push_ok  = (op_data.kind == stpq_pkg::KIND_PUSH) && !is_full;
	assign pop_ok   = (op_data.kind == stpq_pkg::KIND_POP) && !is_empty;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign take[i] = (CW'(i) >= occ_q) || (op_data.minutes <= key_q[i]);

		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (fire && push_ok && take[i]) begin
					key_q[i] <= op_data.minutes;
					id_q[i]  <= op_data.item_id;
				end else if (fire && pop_ok) begin
					key_q[i] <= key_q[i+1];
					id_q[i]  <= id_q[i+1];
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (fire && push_ok && take[i]) begin
					if (take[i-1]) begin
						key_q[i] <= key_q[i-1];
						id_q[i]  <= id_q[i-1];
					end else begin
						key_q[i] <= op_data.minutes;
						id_q[i]  <= op_data.item_id;
					end
				end else if (fire && pop_ok && (i < DEPTH - 1)) begin
					key_q[i] <= key_q[(i+1) % DEPTH];
					id_q[i]  <= id_q[(i+1) % DEPTH];
				end
			end
		end
	end

	always_comb begin
		occ_nxt = occ_q;
		if (push_ok) begin
			occ_nxt = occ_q + CW'(1);
		end else if (pop_ok) begin
			occ_nxt = occ_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (fire) begin
			occ_q <= occ_nxt;
		end
	end

	always_comb begin
		res_data.entry_count = 5'(occ_nxt);
		if (push_ok && take[0]) begin
			res_data.head_id      = op_data.item_id;
			res_data.head_minutes = op_data.minutes;
		end else if (pop_ok) begin
			res_data.head_id      = id_q[1];
			res_data.head_minutes = key_q[1];
		end else begin
			res_data.head_id      = id_q[0];
			res_data.head_minutes = key_q[0];
		end
		if (occ_nxt == '0) begin
			res_data.head_id      = '0;
			res_data.head_minutes = '0;
		end
		case (op_data.kind)
			stpq_pkg::KIND_PUSH: begin
				res_data.status = is_full ? stpq_pkg::STATUS_PUSH_FULL : stpq_pkg::STATUS_OK;
			end
			stpq_pkg::KIND_POP: begin
				res_data.status = is_empty ? stpq_pkg::STATUS_POP_EMPTY : stpq_pkg::STATUS_OK;
			end
			default: begin
				res_data.status = stpq_pkg::STATUS_OK;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: design/sorted_time_priority_queue_top.sv
// Top level of the sorted time priority queue
//
//  channel  handshake     payload
//  input    push / full   kind, item_id, arrival_hhmm
//  result   pop / empty   head_id, head_minutes, entry_count, status
//
// One word per cycle sustained in both directions while results are popped;
// every word gives one result. A result passes through the front conversion
// register, the operation queue and the insert or shift of the sorted chain
// into the result queue before it shows on the ports.
// Reset clears the counts and the occupancy; store contents stay unwritten.
// A stalled result side fills the two-entry queues, then raises full.
`default_nettype none
module sorted_time_priority_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        kind,
	input  wire logic [7:0]  item_id,
	input  wire logic [11:0] arrival_hhmm,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       head_id,
	output logic [10:0]      head_minutes,
	output logic [4:0]       entry_count,
	output logic [1:0]       status
);

	localparam int OP_W  = $bits(stpq_pkg::op_t);
	localparam int RES_W = $bits(stpq_pkg::res_t);

	logic           op_wr;
	logic           op_full;
	logic           op_rd;
	logic           op_empty;
	stpq_pkg::op_t  op_in;
	stpq_pkg::op_t  op_out;
	logic           res_wr;
	logic           res_full;
	stpq_pkg::res_t res_in;
	stpq_pkg::res_t res_out;

	stpq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.item_id      (item_id),
		.arrival_hhmm (arrival_hhmm),
		.op_wr        (op_wr),
		.op_data      (op_in),
		.op_full      (op_full)
	);

	stpq_fifo #(.W(OP_W)) u_op_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (op_wr),
		.wr_data (op_in),
		.full    (op_full),
		.rd_en   (op_rd),
		.rd_data (op_out),
		.empty   (op_empty)
	);

	stpq_back #(.DEPTH(QUEUE_DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (!op_empty),
		.op_data  (op_out),
		.op_rd    (op_rd),
		.res_full (res_full),
		.res_wr   (res_wr),
		.res_data (res_in)
	);

	stpq_fifo #(.W(RES_W)) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign head_id      = res_out.head_id;
	assign head_minutes = res_out.head_minutes;
	assign entry_count  = res_out.entry_count;
	assign status       = res_out.status;

endmodule
`default_nettype wire

FILE: design/stpq_checker.sv
// Port-level checks for the sorted time priority queue
`default_nettype none
`include "sorted_time_priority_queue_top_assert.svh"
module stpq_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [7:0]  head_id,
	input wire logic [10:0] head_minutes,
	input wire logic [4:0]  entry_count,
	input wire logic [1:0]  status
);

	`STPQ_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> empty)
	`STPQ_ASSERT(a_empty_head_zero, (!empty && entry_count == 5'd0) |-> (head_id == 8'd0 && head_minutes == 11'd0))
	`STPQ_ASSERT(a_pop_empty_count, (!empty && status == stpq_pkg::STATUS_POP_EMPTY) |-> (entry_count == 5'd0))
	`STPQ_ASSERT(a_drop_full_count, (!empty && status == stpq_pkg::STATUS_PUSH_FULL) |-> (entry_count == 5'(QUEUE_DEPTH)))
	`STPQ_ASSERT(a_result_hold, (!empty && !pop) |=> (!empty && $stable(head_id) && $stable(entry_count)))

endmodule

bind sorted_time_priority_queue_top stpq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_stpq_checker (.*);
`default_nettype wire
